### hw/rtl/ldfd_pkg.sv
// shared types and constants for the laser distance frame decoder
package ldfd_pkg;

  // number of sensor channels in use, 1 to 16
  localparam int unsigned NUM_CHANNELS = 4;
  localparam int unsigned CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // byte tags in bits 7..6
  localparam logic [1:0] TAG_LOW  = 2'b00;
  localparam logic [1:0] TAG_MID  = 2'b01;
  localparam logic [1:0] TAG_HIGH = 2'b10;

  // distance arithmetic: floor(raw*51*4096/4095) - 32768
  localparam int unsigned RAW_W  = 16;
  localparam int unsigned X_W    = 22;
  localparam int unsigned Q_W    = 10;
  localparam int unsigned DIST_W = 23;
  localparam logic [X_W-1:0]    DIST_DIV    = X_W'(4095);
  localparam logic [DIST_W-1:0] DIST_OFFSET = DIST_W'(32768);

  typedef enum logic [1:0] {
    PH_LOW  = 2'd0,
    PH_MID  = 2'd1,
    PH_HIGH = 2'd2
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic [5:0] low_bits;
    logic [5:0] mid_bits;
  } entry_t;

  typedef struct packed {
    logic [3:0]       channel;
    logic [RAW_W-1:0] raw;
  } result_t;

endpackage

### hw/rtl/laser_distance_frame_decoder.sv
// path: a byte that completes a frame goes through the state stage, p1, p2 and the output register
// throughput: one byte per cycle while in_stall is low; a same-channel byte on the next cycle is
//   served by forwarding around the registered state memory read
// reset: frame trackers of all channels expect a low byte; no clearing pass,
//   per-channel valid bits are cleared at once
module laser_distance_frame_decoder (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [3:0]                         channel,
  input  logic [7:0]                         rx_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [3:0]                         out_channel,
  output logic [ldfd_pkg::RAW_W-1:0]         raw_value,
  output logic signed [ldfd_pkg::DIST_W-1:0] distance_q16
);
  import ldfd_pkg::*;

  logic    res_valid;
  logic    res_stall;
  result_t res;

  ldfd_state u_state (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .channel   (channel),
    .rx_byte   (rx_byte),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  ldfd_dist u_dist (
    .clk          (clk),
    .rst          (rst),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .res          (res),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_channel  (out_channel),
    .raw_value    (raw_value),
    .distance_q16 (distance_q16)
  );

`ifndef SYNTHESIS
  logic [DIST_W-1:0] chk_x;
  logic [DIST_W-1:0] chk_diff;
  assign chk_x    = DIST_W'(raw_value) * DIST_W'(51);
  assign chk_diff = $unsigned(distance_q16) + DIST_OFFSET - chk_x;

  // results only come from channels in use
  a_out_channel: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, out_channel} < 5'(NUM_CHANNELS)))
    else $error("result from channel out of range");

  // input stalls only when a completed frame is blocked downstream
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (res_valid && res_stall))
    else $error("input stalled without a blocked result");

  // distance plus 32768 lies between raw*51 and raw*51 + 816, the largest raw*51/4095
  a_dist_bracket: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (chk_diff <= DIST_W'(816)))
    else $error("distance does not match raw value");
`endif

endmodule

### hw/rtl/ldfd_state.sv
// per-channel frame tracker state memory with read-modify-write and forwarding
module ldfd_state (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [3:0]        channel,
  input  logic [7:0]        rx_byte,
  output logic              res_valid,
  input  logic              res_stall,
  output ldfd_pkg::result_t res
);
  import ldfd_pkg::*;

  entry_t                  mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] vld;

  logic             s1_valid;
  logic [3:0]       s1_channel;
  logic [7:0]       s1_byte;
  logic             rd_vld;
  entry_t           rd_entry;
  logic             byp;
  entry_t           byp_entry;

  logic             in_range;
  logic             accept;
  logic [CH_W-1:0]  in_addr;
  logic [CH_W-1:0]  s1_addr;
  logic             s1_fire;
  logic             emit;
  logic [1:0]       tag;
  entry_t           cur;
  entry_t           entry_next;

  assign in_addr  = channel[CH_W-1:0];
  assign s1_addr  = s1_channel[CH_W-1:0];
  assign in_range = ({1'b0, channel} < 5'(NUM_CHANNELS));
  assign in_stall = s1_valid && !s1_fire;
  assign accept   = in_valid && !in_stall;
  assign tag      = s1_byte[7:6];

  always_comb begin
    if (byp) begin
      cur = byp_entry;
    end else if (rd_vld) begin
      cur = rd_entry;
    end else begin
      cur = '{phase: PH_LOW, low_bits: 6'd0, mid_bits: 6'd0};
    end
    entry_next = cur;
    emit       = 1'b0;
    case (cur.phase)
      PH_MID: begin
        if (tag == TAG_MID) begin
          entry_next.mid_bits = s1_byte[5:0];
          entry_next.phase    = PH_HIGH;
        end else begin
          entry_next.phase = PH_LOW;
        end
      end
      PH_HIGH: begin
        entry_next.phase = PH_LOW;
        emit             = (tag == TAG_HIGH);
      end
      default: begin
        if (tag == TAG_LOW) begin
          entry_next.low_bits = s1_byte[5:0];
          entry_next.phase    = PH_MID;
        end else begin
          entry_next.phase = PH_LOW;
        end
      end
    endcase
  end

  assign s1_fire     = s1_valid && (!emit || !res_stall);
  assign res_valid   = s1_valid && emit;
  assign res.channel = s1_channel;
  assign res.raw     = {s1_byte[3:0], cur.mid_bits, cur.low_bits};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      vld      <= '0;
      byp      <= 1'b0;
      rd_vld   <= 1'b0;
    end else begin
      if (s1_fire) begin
        s1_valid     <= 1'b0;
        vld[s1_addr] <= 1'b1;
      end
      if (accept && in_range) begin
        s1_valid <= 1'b1;
        rd_vld   <= vld[in_addr];
        // write of the previous item to the same entry lands at this edge
        byp      <= s1_fire && (s1_addr == in_addr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      mem[s1_addr] <= entry_next;
    end
    if (accept && in_range) begin
      s1_channel <= channel;
      s1_byte    <= rx_byte;
      rd_entry   <= mem[in_addr];
      byp_entry  <= entry_next;
    end
  end

endmodule

### hw/rtl/ldfd_dist.sv
// distance pipeline: raw*51, reciprocal estimate of /4095, correction, output register
module ldfd_dist (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             res_valid,
  output logic                             res_stall,
  input  ldfd_pkg::result_t                res,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [3:0]                       out_channel,
  output logic [ldfd_pkg::RAW_W-1:0]       raw_value,
  output logic signed [ldfd_pkg::DIST_W-1:0] distance_q16
);
  import ldfd_pkg::*;

  logic             p1_valid;
  result_t          p1_res;
  logic [X_W-1:0]   p1_x;
  logic             p2_valid;
  result_t          p2_res;
  logic [X_W-1:0]   p2_x;
  logic [Q_W-1:0]   p2_q;

  logic             out_load;
  logic             p2_load;
  logic             p1_load;
  logic [X_W-1:0]   x_in;
  logic [X_W+12-1:0] x_recip;
  logic [Q_W-1:0]   q_est;
  logic [X_W-1:0]   q_mul;
  logic [X_W-1:0]   rem;
  logic [Q_W-1:0]   q_fix;
  logic [DIST_W-1:0] dist_val;

  assign out_load  = !out_valid || !out_stall;
  assign p2_load   = !p2_valid || out_load;
  assign p1_load   = !p1_valid || p2_load;
  assign res_stall = !p1_load;

  // raw * 51 as shift-adds
  assign x_in = {1'b0, res.raw, 5'b0} + {2'b0, res.raw, 4'b0} + {5'b0, res.raw, 1'b0}
              + {6'b0, res.raw};

  // x*4097 >> 24 is floor(x/4095) or one less
  assign x_recip = {12'b0, p1_x} + {p1_x, 12'b0};
  assign q_est   = x_recip[X_W+12-1:24];

  // remainder check against 4095, q*4095 = (q<<12) - q
  assign q_mul    = {p2_q, 12'b0} - {{(X_W-Q_W){1'b0}}, p2_q};
  assign rem      = p2_x - q_mul;
  assign q_fix    = (rem >= DIST_DIV) ? (p2_q + Q_W'(1)) : p2_q;
  assign dist_val = {1'b0, p2_x} + {{(DIST_W-Q_W){1'b0}}, q_fix} - DIST_OFFSET;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid  <= 1'b0;
      p2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (p1_load) begin
        p1_valid <= res_valid;
      end
      if (p2_load) begin
        p2_valid <= p1_valid;
      end
      if (out_load) begin
        out_valid <= p2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p1_load && res_valid) begin
      p1_res <= res;
      p1_x   <= x_in;
    end
    if (p2_load && p1_valid) begin
      p2_res <= p1_res;
      p2_x   <= p1_x;
      p2_q   <= q_est;
    end
    if (out_load && p2_valid) begin
      out_channel  <= p2_res.channel;
      raw_value    <= p2_res.raw;
      distance_q16 <= $signed(dist_val);
    end
  end

endmodule

### tb/sv/tb_top.sv
// self-checking testbench for the laser distance frame decoder
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ldfd_pkg::*;

  localparam longint unsigned Q16_MUL  = 3342336;
  localparam longint unsigned Q16_DEN  = 65520;
  localparam longint unsigned Q16_HALF = 32768;
  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_CYCLES = 20;
  localparam int RANDOM_BYTES = 1800;

  class frame_scoreboard;
    typedef struct {
      logic [3:0]  ch;
      logic [15:0] raw;
      logic [22:0] distance;
    } frame_t;

    phase_t     phase [16];
    logic [5:0] low_bits [16];
    logic [5:0] mid_bits [16];
    frame_t     pending_frames [$];
    int         errors;

    function new();
      foreach (phase[i]) begin
        phase[i] = PH_LOW;
        low_bits[i] = '0;
        mid_bits[i] = '0;
      end
      errors = 0;
    endfunction

    // advance the channel's frame tracker by one accepted byte
    function void note_byte(logic [3:0] ch, logic [7:0] b);
      frame_t f;
      longint unsigned q;
      if (ch >= NUM_CHANNELS) return;
      case (phase[ch])
        PH_MID: begin
          if (b[7:6] == TAG_MID) begin
            mid_bits[ch] = b[5:0];
            phase[ch] = PH_HIGH;
          end else begin
            phase[ch] = PH_LOW;
          end
        end
        PH_HIGH: begin
          phase[ch] = PH_LOW;
          if (b[7:6] == TAG_HIGH) begin
            f.ch = ch;
            f.raw = {b[3:0], mid_bits[ch], low_bits[ch]};
            q = 64'(f.raw) * Q16_MUL / Q16_DEN;
            // wraps below zero, the low 23 bits are the two's complement value
            f.distance = 23'(q - Q16_HALF);
            pending_frames.push_back(f);
          end
        end
        default: begin
          if (b[7:6] == TAG_LOW) begin
            low_bits[ch] = b[5:0];
            phase[ch] = PH_MID;
          end else begin
            phase[ch] = PH_LOW;
          end
        end
      endcase
    endfunction

    function void check_frame(logic [3:0] ch, logic [15:0] raw, logic [22:0] distance);
      frame_t f;
      if (pending_frames.size() == 0) begin
        errors++;
        $display("%0t: frame with none expected: channel %0d raw %h distance %h",
                 $time, ch, raw, distance);
        return;
      end
      f = pending_frames.pop_front();
      if (ch !== f.ch) begin
        errors++;
        $display("%0t: out_channel expected %0d got %0d", $time, f.ch, ch);
      end
      if (raw !== f.raw) begin
        errors++;
        $display("%0t: raw_value expected %h got %h", $time, f.raw, raw);
      end
      if (distance !== f.distance) begin
        errors++;
        $display("%0t: distance_q16 expected %h got %h", $time, f.distance, distance);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  channel = '0;
  logic [7:0]  rx_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_channel;
  logic [RAW_W-1:0] raw_value;
  logic signed [DIST_W-1:0] distance_q16;

  frame_scoreboard sb = new();
  int idle_cycles = 0;
  bit sender_calm = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  laser_distance_frame_decoder u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .channel      (channel),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_channel  (out_channel),
    .raw_value    (raw_value),
    .distance_q16 (distance_q16)
  );

  task automatic send_byte(input logic [3:0] ch, input logic [7:0] b);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 14);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    channel <= ch;
    rx_byte <= b;
    do @(posedge clk); while (in_stall);
    sb.note_byte(ch, b);
  endtask

  task automatic wait_all_frames();
    while (sb.pending_frames.size() != 0) @(posedge clk);
  endtask

  // receiver: random stall before each item, with calm stretches
  initial begin
    int w;
    int taken;
    bit calm;
    taken = 0;
    calm = 1'b0;
    forever begin
      if (taken % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      w = calm ? 0 : $urandom_range(0, 14);
      repeat (w) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (rst || !out_valid);
      taken++;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_frame(out_channel, raw_value, distance_q16);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    // {channel, byte}
    logic [11:0] directed [$];
    logic [3:0]  ch;
    logic [7:0]  b;
    int n;
    directed = '{
      12'h000, 12'h040, 12'h080,                  // all-zero frame
      12'h13F, 12'h17F, 12'h1BF,                  // all-ones frame, high bits 5..4 set
      12'h215, 12'h5FF, 12'h26A, 12'h32A, 12'h2B5, // interleaved, out-of-range in between
      12'h301, 12'h3C3, 12'h341, 12'h385,          // low tag in mid phase, bad tags at low
      12'h010, 12'h050, 12'h011, 12'h055,          // low tag in high phase
      12'h120, 12'h160, 12'h1C0, 12'hF00, 12'h43F, // tag 11 in high phase, ignored channels
      12'h201, 12'h2FF                             // tag 11 in mid phase
    };

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_byte(directed[i][11:8], directed[i][7:0]);
    @(negedge clk);
    in_valid <= 1'b0;
    wait_all_frames();

    n = 0;
    while (n < RANDOM_BYTES) begin
      if (n % 150 == 0) sender_calm = ($urandom_range(0, 3) == 0);
      // hold off the sender at the halfway point until the output side has drained
      if (n == RANDOM_BYTES / 2) begin
        @(negedge clk);
        in_valid <= 1'b0;
        wait_all_frames();
      end
      if (NUM_CHANNELS < 16 && $urandom_range(0, 9) == 0) begin
        ch = 4'($urandom_range(NUM_CHANNELS, 15));
        b = 8'($urandom_range(0, 255));
      end else begin
        ch = 4'($urandom_range(0, NUM_CHANNELS - 1));
        n++;
        if ($urandom_range(0, 7) == 0) begin
          b = 8'($urandom_range(0, 255));
        end else begin
          case (sb.phase[ch])
            PH_MID:  b = {TAG_MID, 6'($urandom)};
            PH_HIGH: b = {TAG_HIGH, 6'($urandom)};
            default: b = {TAG_LOW, 6'($urandom)};
          endcase
        end
      end
      send_byte(ch, b);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    wait_all_frames();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/ldfd_pkg.sv
hw/rtl/ldfd_state.sv
hw/rtl/ldfd_dist.sv
hw/rtl/laser_distance_frame_decoder.sv
tb/sv/tb_top.sv
